### rtl/core/nldt_pkg.sv
// ----------------------------------------------------------------------------
// nldt_pkg: shared definitions for the lag-and-dead-time plant model
// Field widths, register indexes, reset values and size defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package nldt_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 16;
  localparam int COEF_W      = 16;
  localparam int CFG_ORDER_W = 4;
  localparam int CFG_DELAY_W = 9;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int STAGE_W     = 32;

  localparam int DEF_MAX_ORDER = 8;
  localparam int DEF_MAX_DELAY = 256;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 4'd3;

  localparam logic signed [GAIN_W-1:0] GAIN_RST  = 16'sd256;
  localparam logic [COEF_W-1:0]        COEF_RST  = 16'd60000;
  localparam logic [CFG_ORDER_W-1:0]   ORDER_RST = 4'd1;
  localparam logic [CFG_DELAY_W-1:0]   DELAY_RST = 9'd0;

endpackage

`default_nettype wire

### rtl/core/nldt_ram.sv
// ----------------------------------------------------------------------------
// nldt_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nldt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/nth_order_lag_dead_time.sv
// ----------------------------------------------------------------------------
// nth_order_lag_dead_time: cascaded first-order lags with a dead-time line
// One sample per tick runs through up to MAX_ORDER identical lag stages on a
// shared multiplier, then through a ring-buffer delay of delay_steps ticks.
// ----------------------------------------------------------------------------
//
//  channel | signals                                  | direction | transfer when
//  --------+------------------------------------------+-----------+------------------------
//  input   | in_valid, in_stall, sample_in            | into core | in_valid && !in_stall
//  output  | out_valid, out_stall, sample_out         | from core | out_valid && !out_stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data| into core | cfg_valid && cfg_ready
//
//  Samples are worked one at a time, at a pace set by the one 17x33 multiplier
//  shared by the gain product and every stage update (a read and a write step a stage).
//  Reset (rst, synchronous) restores register defaults, clears the stage valid
//  bits and the delay fill count; no clearing pass over the delay memory.
//  Any config write to a known register clears the stores the same way.
//  in_stall is high while a sample is in work; the finished result waits in
//  the output register, and a new sample is taken while it waits there.
//
`default_nettype none

module nth_order_lag_dead_time
  import nldt_pkg::*;
#(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  parameter int MAX_DELAY = DEF_MAX_DELAY
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [SAMPLE_W-1:0]   sample_in,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [SAMPLE_W-1:0]        sample_out,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int SW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int OW = ($clog2(MAX_ORDER + 1) > CFG_ORDER_W) ? $clog2(MAX_ORDER + 1)
                                                             : CFG_ORDER_W;
  localparam int PW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int DW = ($clog2(MAX_DELAY + 1) > CFG_DELAY_W) ? $clog2(MAX_DELAY + 1)
                                                             : CFG_DELAY_W;
  localparam int MA_W = COEF_W + 1;
  localparam int MB_W = STAGE_W + 1;
  localparam int MP_W = MA_W + MB_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GAIN = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // configuration registers
  logic signed [GAIN_W-1:0]  gain;
  logic [COEF_W-1:0]         decay_coef;
  logic [CFG_ORDER_W-1:0]    order;
  logic [CFG_DELAY_W-1:0]    delay_steps;

  logic [2:0]                state;
  logic [SW-1:0]             idx;
  logic [MAX_ORDER-1:0]      st_vld;
  logic                      st_vld_q;
  logic signed [STAGE_W-1:0] cur;
  logic signed [STAGE_W-1:0] u_r;
  logic signed [STAGE_W-1:0] u0;
  logic signed [STAGE_W-1:0] out_pre;
  logic signed [MP_W-1:0]    prod;
  logic [PW-1:0]             wp;
  logic [DW-1:0]             fill;

  logic                      in_xfer;
  logic                      cfg_xfer;
  logic                      cfg_hit;
  logic [OW-1:0]             n_eff;
  logic [SW-1:0]             n_m1;
  logic [DW-1:0]             d_eff;
  logic [DW-1:0]             dm1;
  logic [DW:0]               rd_sum;
  logic [PW-1:0]             dl_raddr;

  logic                      st_re;
  logic [SW-1:0]             st_raddr;
  logic                      st_we;
  logic [STAGE_W-1:0]        st_rdata;
  logic [STAGE_W-1:0]        dl_rdata;
  logic                      dl_we;

  logic signed [STAGE_W-1:0] s_prev;
  logic signed [STAGE_W-1:0] u_sel;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [MP_W-1:0]    blend_sum;
  logic signed [STAGE_W-1:0] blend_res;
  logic signed [STAGE_W:0]   rnd_sum;
  logic signed [STAGE_W-8:0] rnd_val;
  logic signed [SAMPLE_W-1:0] sat_val;
  logic signed [STAGE_W-1:0] tail;

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_xfer && ((cfg_index == REG_GAIN) || (cfg_index == REG_COEF) ||
                                  (cfg_index == REG_ORDER) || (cfg_index == REG_DELAY));

  // effective order and delay: order of zero acts as one, both saturate
  always_comb begin
    if (order == '0) begin
      n_eff = OW'(1);
    end else if (OW'(order) > OW'(MAX_ORDER)) begin
      n_eff = OW'(MAX_ORDER);
    end else begin
      n_eff = OW'(order);
    end
    n_m1 = SW'(n_eff - OW'(1));
    if (DW'(delay_steps) > DW'(MAX_DELAY)) begin
      d_eff = DW'(MAX_DELAY);
    end else begin
      d_eff = DW'(delay_steps);
    end
    dm1 = d_eff - DW'(1);
  end

  // ring read address: the cell written d-1 ticks ago
  always_comb begin
    rd_sum = (DW + 1)'(wp) + (DW + 1)'(MAX_DELAY) - (DW + 1)'(dm1);
    if (rd_sum >= (DW + 1)'(MAX_DELAY)) begin
      rd_sum = rd_sum - (DW + 1)'(MAX_DELAY);
    end
    dl_raddr = PW'(rd_sum);
  end

  // stage store read sequencing: last stage first, then one below each step
  always_comb begin
    st_re    = 1'b0;
    st_raddr = idx;
    case (state)
      S_IDLE: begin
        st_re    = in_xfer;
        st_raddr = n_m1;
      end
      S_GAIN: begin
        st_re    = (idx != '0);
        st_raddr = idx - SW'(1);
      end
      S_WR: begin
        st_re    = (idx > SW'(1));
        st_raddr = idx - SW'(2);
      end
      default: begin
        st_re    = 1'b0;
        st_raddr = idx;
      end
    endcase
  end

  assign s_prev = st_vld_q ? signed'(st_rdata) : '0;
  assign u_sel  = (idx != '0) ? s_prev : u0;

  // shared multiplier operands: gain*x on accept, a*(s-u) in each stage step
  always_comb begin
    if (state == S_IDLE) begin
      mul_a = MA_W'(gain);
      mul_b = MB_W'(sample_in);
    end else begin
      mul_a = signed'({1'b0, decay_coef});
      mul_b = MB_W'(cur) - MB_W'(u_sel);
    end
  end

  // a*s + (1-a)*u = u<<16 + a*(s-u); round half up, floor shift
  always_comb begin
    blend_sum = (MP_W'(u_r) <<< COEF_W) + prod + MP_W'(32'sd32768);
    blend_res = blend_sum[COEF_W +: STAGE_W];
  end

  // output rounding and saturation
  always_comb begin
    rnd_sum = (STAGE_W + 1)'(out_pre) + (STAGE_W + 1)'(33'sd128);
    rnd_val = rnd_sum[STAGE_W:8];
    if (rnd_val > (STAGE_W - 7)'(32767)) begin
      sat_val = 16'sh7fff;
    end else if (rnd_val < -(STAGE_W - 7)'(32768)) begin
      sat_val = -16'sh8000;
    end else begin
      sat_val = SAMPLE_W'(rnd_val);
    end
  end

  // delay tail: direct for one tick, memory once filled, else zero
  always_comb begin
    if (d_eff == DW'(1)) begin
      tail = s_prev;
    end else if (fill >= dm1) begin
      tail = signed'(dl_rdata);
    end else begin
      tail = '0;
    end
  end

  assign st_we = (state == S_WR);
  assign dl_we = (state == S_GAIN) && (d_eff != '0);

  nldt_ram #(
    .WIDTH (STAGE_W),
    .DEPTH (MAX_ORDER)
  ) u_stage_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (idx),
    .wdata (blend_res),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  nldt_ram #(
    .WIDTH (STAGE_W),
    .DEPTH (MAX_DELAY)
  ) u_delay_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (wp),
    .wdata (s_prev),
    .re    (in_xfer),
    .raddr (dl_raddr),
    .rdata (dl_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain        <= GAIN_RST;
      decay_coef  <= COEF_RST;
      order       <= ORDER_RST;
      delay_steps <= DELAY_RST;
    end else if (cfg_xfer) begin
      case (cfg_index)
        REG_GAIN:  gain        <= signed'(cfg_data[GAIN_W-1:0]);
        REG_COEF:  decay_coef  <= cfg_data[COEF_W-1:0];
        REG_ORDER: order       <= cfg_data[CFG_ORDER_W-1:0];
        REG_DELAY: delay_steps <= cfg_data[CFG_DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer and store bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      st_vld <= '0;
      wp     <= '0;
      fill   <= '0;
    end else begin
      if (cfg_hit) begin
        st_vld <= '0;
        wp     <= '0;
        fill   <= '0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          if (dl_we) begin
            wp <= (wp == PW'(MAX_DELAY - 1)) ? '0 : wp + PW'(1);
            if (fill < DW'(MAX_DELAY)) begin
              fill <= fill + DW'(1);
            end
          end
          state <= S_RD;
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          st_vld[idx] <= 1'b1;
          state       <= (idx == '0) ? S_OUT : S_RD;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (st_re) begin
      st_vld_q <= st_vld[st_raddr];
    end
    if (state == S_IDLE || state == S_RD) begin
      prod <= mul_a * mul_b;
    end
    case (state)
      S_IDLE: begin
        idx <= n_m1;
      end
      S_GAIN: begin
        cur <= s_prev;
        u0  <= prod[STAGE_W-1:0];
        if (d_eff != '0) begin
          out_pre <= tail;
        end
      end
      S_RD: begin
        u_r <= u_sel;
      end
      S_WR: begin
        // hold the old lower stage as the next step's own value
        cur <= u_r;
        if (idx == n_m1 && d_eff == '0) begin
          out_pre <= blend_res;
        end
        if (idx != '0) begin
          idx <= idx - SW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // output register: load when empty or being taken, drop after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      sample_out <= sat_val;
    end
  end

endmodule

`default_nettype wire

### rtl/core/nldt_checker.sv
// ----------------------------------------------------------------------------
// nldt_checker: port-level checks for the lag-and-dead-time plant model
// Watches the top-level channels over time; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module nldt_checker
  import nldt_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic signed [SAMPLE_W-1:0] sample_in,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic signed [SAMPLE_W-1:0] sample_out,
  input wire logic                       cfg_valid,
  input wire logic                       cfg_ready,
  input wire logic [CFG_IDX_W-1:0]       cfg_index,
  input wire logic [CFG_DATA_W-1:0]      cfg_data
);

  // a result waiting on a stalled sink stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output valid dropped while stalled");

  // an accepted sample occupies the core for at least the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // no result can follow the accept edge directly
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after accept");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind nth_order_lag_dead_time nldt_checker u_nldt_checker (.*);

`default_nettype wire
